>>> hdl/pqe_pkg.sv
// Package of the product quantizer encode unit: parameter defaults,
// register indexes and the structs that pass between front, back and top.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pqe_pkg;

   localparam int DefMaxSubspaces = 8;
   localparam int DefMaxCentroids = 256;
   localparam int DefMaxSubDim    = 16;
   localparam int DefValueBits    = 16;

   localparam int CsrIndexBits = 2;
   localparam int CsrDataBits  = 5;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_NUM_SUBSPACES = 2'd0,
      CSR_CENTROID_BITS = 2'd1,
      CSR_SUB_DIM       = 2'd2
   } csr_index_type;

   localparam logic FUNC_BOOK_WRITE = 1'b0;
   localparam logic FUNC_ELEMENT    = 1'b1;

   typedef struct packed {
      logic [3:0] num_subspaces;
      logic [3:0] centroid_bits;
      logic [4:0] sub_dim;
   } cfg_type;

   typedef struct packed {
      logic is_elem;
      logic wr_ok;
   } item_ctl_type;

   typedef struct packed {
      logic [1:0] count;
      logic       full;
   } front_status_type;

   typedef struct packed {
      logic busy;
      logic finishing;
   } back_status_type;

endpackage
`default_nettype wire

>>> hdl/pqe_req_if.sv
// Input item channel of the encode unit: valid, ready and the item fields.
// Uses nothing else.
`timescale 1ns / 1ps
`default_nettype none
interface pqe_req_if #(parameter int VALUE_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [2:0]                   book_subspace;
   logic [7:0]                   book_centroid;
   logic [3:0]                   book_component;
   logic signed [VALUE_BITS-1:0] value;
   modport source (output valid, func, book_subspace, book_centroid, book_component, value,
                   input ready);
   modport sink (input valid, func, book_subspace, book_centroid, book_component, value,
                 output ready);
endinterface
`default_nettype wire

>>> hdl/pqe_rsp_if.sv
// Result channel of the encode unit: valid, ready, code, subspace, end mark.
// Uses nothing else.
`timescale 1ns / 1ps
`default_nettype none
interface pqe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code;
   logic [2:0] subspace;
   logic       vector_done;
   modport source (output valid, code, subspace, vector_done, input ready);
   modport sink (input valid, code, subspace, vector_done, output ready);
endinterface
`default_nettype wire

>>> hdl/pqe_csr_if.sv
// Register write channel of the encode unit: valid, ready, index and data.
// Uses the widths of pqe_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pqe_csr_if;
   logic                          valid;
   logic                          ready;
   logic [pqe_pkg::CsrIndexBits-1:0] index;
   logic [pqe_pkg::CsrDataBits-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/pqe_front.sv
// Front of the encode unit: accepts items, classifies them and holds them
// in a two-entry queue for the back. Depends on pqe_pkg and pqe_req_if.
`timescale 1ns / 1ps
`default_nettype none
module pqe_front
   import pqe_pkg::*;
#(
   parameter int MAX_SUBSPACES = DefMaxSubspaces,
   parameter int MAX_CENTROIDS = DefMaxCentroids,
   parameter int MAX_SUB_DIM   = DefMaxSubDim,
   parameter int VALUE_BITS    = DefValueBits,
   localparam int SW = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1,
   localparam int CW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1,
   localparam int KW = (MAX_SUB_DIM > 1) ? $clog2(MAX_SUB_DIM) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   pqe_req_if.sink                      req_if,
   output item_ctl_type                 head_ctl,
   output logic [SW-1:0]                head_subspace,
   output logic [CW-1:0]                head_centroid,
   output logic [KW-1:0]                head_component,
   output logic signed [VALUE_BITS-1:0] head_value,
   output logic                         head_valid,
   input  wire logic                    head_pop,
   output front_status_type             status
);

   localparam int Depth = 2;

   item_ctl_type                 ctl_ff   [Depth];
   logic [SW-1:0]                sub_ff   [Depth];
   logic [CW-1:0]                cent_ff  [Depth];
   logic [KW-1:0]                comp_ff  [Depth];
   logic signed [VALUE_BITS-1:0] value_ff [Depth];
   logic                         wr_ptr_ff, wr_ptr_in;
   logic                         rd_ptr_ff, rd_ptr_in;
   logic [1:0]                   count_ff, count_in;
   logic                         push;
   item_ctl_type                 new_ctl;

   assign req_if.ready = (count_ff != 2'(Depth));
   assign push = req_if.valid && req_if.ready;

   always_comb begin
      new_ctl.is_elem = (req_if.func == FUNC_ELEMENT);
      new_ctl.wr_ok = (32'(req_if.book_subspace) < MAX_SUBSPACES) &&
                      (32'(req_if.book_centroid) < MAX_CENTROIDS) &&
                      (32'(req_if.book_component) < MAX_SUB_DIM);
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_ff[wr_ptr_ff]   <= new_ctl;
         sub_ff[wr_ptr_ff]   <= SW'(req_if.book_subspace);
         cent_ff[wr_ptr_ff]  <= CW'(req_if.book_centroid);
         comp_ff[wr_ptr_ff]  <= KW'(req_if.book_component);
         value_ff[wr_ptr_ff] <= req_if.value;
      end
   end

   assign head_valid     = (count_ff != 2'd0);
   assign head_ctl       = ctl_ff[rd_ptr_ff];
   assign head_subspace  = sub_ff[rd_ptr_ff];
   assign head_centroid  = cent_ff[rd_ptr_ff];
   assign head_component = comp_ff[rd_ptr_ff];
   assign head_value     = value_ff[rd_ptr_ff];

   assign status.count = count_ff;
   assign status.full  = !req_if.ready;

endmodule
`default_nettype wire

>>> hdl/pqe_back.sv
// Back of the encode unit: codebook and running-sum memories, the distance
// pipeline, the nearest-centroid search and the result register.
// Depends on pqe_pkg and pqe_rsp_if.
`timescale 1ns / 1ps
`default_nettype none
module pqe_back
   import pqe_pkg::*;
#(
   parameter int MAX_SUBSPACES = DefMaxSubspaces,
   parameter int MAX_CENTROIDS = DefMaxCentroids,
   parameter int MAX_SUB_DIM   = DefMaxSubDim,
   parameter int VALUE_BITS    = DefValueBits,
   localparam int SW = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1,
   localparam int CW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1,
   localparam int KW = (MAX_SUB_DIM > 1) ? $clog2(MAX_SUB_DIM) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cfg_type                 cfg,
   input  wire item_ctl_type            head_ctl,
   input  wire logic [SW-1:0]           head_subspace,
   input  wire logic [CW-1:0]           head_centroid,
   input  wire logic [KW-1:0]           head_component,
   input  wire logic signed [VALUE_BITS-1:0] head_value,
   input  wire logic                    head_valid,
   output logic                         head_pop,
   pqe_rsp_if.source                    rsp_if,
   output back_status_type              status
);

   localparam int AW   = SW + CW + KW;
   localparam int NCW  = $clog2(MAX_CENTROIDS + 1);
   localparam int NSW  = $clog2(MAX_SUBSPACES + 1);
   localparam int SDW  = $clog2(MAX_SUB_DIM + 1);
   localparam int SQW  = 2 * VALUE_BITS;
   localparam int PDW  = SQW + $clog2(MAX_SUB_DIM) + 1;

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_type;

   logic [VALUE_BITS-1:0] cb_mem [2**AW];
   logic [PDW-1:0]        pd_mem [2**CW];

   state_type                    state_ff;
   logic [NCW-1:0]               cnt_ff;
   logic [NCW-1:0]               ncent_ff;
   logic signed [VALUE_BITS-1:0] x_ff;
   logic [SW-1:0]                s_ff;
   logic [KW-1:0]                k_ff;
   logic                         first_ff, last_ff, done_ff;
   logic [KW-1:0]                ep_ff;
   logic [SW-1:0]                sp_ff;
   logic                         v1_ff, v2_ff;
   logic [CW-1:0]                c1_ff, c2_ff;
   logic signed [VALUE_BITS-1:0] cb_rd_ff;
   logic [PDW-1:0]               pd_rd_ff, pd2_ff;
   logic [SQW-1:0]               sq_ff;
   logic [PDW-1:0]               best_d_ff;
   logic [CW-1:0]                best_c_ff;
   logic                         rsp_valid_ff;
   logic [7:0]                   rsp_code_ff;
   logic [2:0]                   rsp_sub_ff;
   logic                         rsp_done_ff;

   logic [NSW-1:0]               ns_e;
   logic [NCW-1:0]               ncent_e;
   logic [SDW-1:0]               sd_e;
   logic [3:0]                   cb_clamp;
   logic [8:0]                   pow;
   logic                         start_elem, start_write, finish;
   logic signed [VALUE_BITS:0]   diff;
   logic signed [2*VALUE_BITS+1:0] prod;
   logic [PDW-1:0]               sum;

   // Register values are saturated into their legal ranges.
   always_comb begin
      if (cfg.num_subspaces == 4'd0) ns_e = NSW'(1);
      else if (32'(cfg.num_subspaces) > MAX_SUBSPACES) ns_e = NSW'(MAX_SUBSPACES);
      else ns_e = NSW'(cfg.num_subspaces);
      if (cfg.sub_dim == 5'd0) sd_e = SDW'(1);
      else if (32'(cfg.sub_dim) > MAX_SUB_DIM) sd_e = SDW'(MAX_SUB_DIM);
      else sd_e = SDW'(cfg.sub_dim);
      if (cfg.centroid_bits < 4'd4) cb_clamp = 4'd4;
      else if (cfg.centroid_bits > 4'd8) cb_clamp = 4'd8;
      else cb_clamp = cfg.centroid_bits;
      pow = 9'd1 << cb_clamp;
      ncent_e = (32'(pow) > MAX_CENTROIDS) ? NCW'(MAX_CENTROIDS) : NCW'(pow);
   end

   assign start_write = (state_ff == S_IDLE) && head_valid && !head_ctl.is_elem;
   assign start_elem  = (state_ff == S_IDLE) && head_valid && head_ctl.is_elem &&
                        !rsp_valid_ff;
   assign head_pop    = start_write || start_elem;
   assign finish      = (state_ff == S_DRAIN) && !v1_ff && !v2_ff;

   always_comb begin
      diff = $signed({cb_rd_ff[VALUE_BITS-1], cb_rd_ff});
      diff = $signed({x_ff[VALUE_BITS-1], x_ff}) - diff;
      prod = diff * diff;
      sum  = first_ff ? PDW'(sq_ff) : pd2_ff + PDW'(sq_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         ep_ff        <= '0;
         sp_ff        <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff <= (state_ff == S_RUN);
         v2_ff <= v1_ff;
         if (rsp_valid_ff && rsp_if.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start_elem) begin
                  cnt_ff   <= '0;
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               cnt_ff <= cnt_ff + NCW'(1);
               if (cnt_ff == ncent_ff - NCW'(1)) state_ff <= S_DRAIN;
            end
            S_DRAIN: begin
               if (finish) begin
                  state_ff <= S_IDLE;
                  if (last_ff) begin
                     rsp_valid_ff <= 1'b1;
                     ep_ff <= '0;
                     sp_ff <= done_ff ? '0 : sp_ff + SW'(1);
                  end else begin
                     ep_ff <= ep_ff + KW'(1);
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (start_elem) begin
         x_ff     <= head_value;
         s_ff     <= sp_ff;
         k_ff     <= ep_ff;
         ncent_ff <= ncent_e;
         first_ff <= (ep_ff == '0);
         last_ff  <= (32'(ep_ff) + 1 >= 32'(sd_e));
         done_ff  <= (32'(sp_ff) + 1 >= 32'(ns_e));
      end
      if (start_write && head_ctl.wr_ok) begin
         cb_mem[{head_subspace, head_centroid, head_component}] <= head_value;
      end
      cb_rd_ff <= cb_mem[{s_ff, cnt_ff[CW-1:0], k_ff}];
      pd_rd_ff <= pd_mem[cnt_ff[CW-1:0]];
      c1_ff    <= cnt_ff[CW-1:0];
      sq_ff    <= prod[SQW-1:0];
      pd2_ff   <= pd_rd_ff;
      c2_ff    <= c1_ff;
      if (v2_ff) begin
         pd_mem[c2_ff] <= sum;
         // Strict compare keeps the lowest index on a tie.
         if (c2_ff == '0 || sum < best_d_ff) begin
            best_d_ff <= sum;
            best_c_ff <= c2_ff;
         end
      end
      if (finish && last_ff) begin
         rsp_code_ff <= 8'(best_c_ff);
         rsp_sub_ff  <= 3'(s_ff);
         rsp_done_ff <= done_ff;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.code        = rsp_code_ff;
   assign rsp_if.subspace    = rsp_sub_ff;
   assign rsp_if.vector_done = rsp_done_ff;

   assign status.busy      = (state_ff != S_IDLE);
   assign status.finishing = finish && last_ff;

endmodule
`default_nettype wire

>>> hdl/product_quantizer_encode_unit.sv
// Top level of the product quantizer encode unit: register file, front
// queue and back engine. Depends on pqe_pkg, the three channel interfaces,
// pqe_front and pqe_back.
//
//   channel  direction  contents
//   req_if   in         func, book_subspace, book_centroid, book_component, value
//   rsp_if   out        code, subspace, vector_done
//   csr_if   in         index, data (register writes, always ready)
//
// A codebook write is done by the back engine from its idle state. An element
// leaves the queue, then passes one centroid per cycle through the codebook
// read port, then drains the read, squaring and running-sum write stages.
// Reset clears control state only; codebook and sums are undefined until written.
// The two-entry queue takes items while the back works; an element waits
// while the previous result is still untaken.
`timescale 1ns / 1ps
`default_nettype none
module product_quantizer_encode_unit
   import pqe_pkg::*;
#(
   parameter int MAX_SUBSPACES = DefMaxSubspaces,
   parameter int MAX_CENTROIDS = DefMaxCentroids,
   parameter int MAX_SUB_DIM   = DefMaxSubDim,
   parameter int VALUE_BITS    = DefValueBits
) (
   input wire logic clock,
   input wire logic reset,
   pqe_req_if.sink   req_if,
   pqe_rsp_if.source rsp_if,
   pqe_csr_if.sink   csr_if
);

   localparam int SW = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1;
   localparam int CW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
   localparam int KW = (MAX_SUB_DIM > 1) ? $clog2(MAX_SUB_DIM) : 1;

   cfg_type                      cfg_ff;
   item_ctl_type                 head_ctl;
   logic [SW-1:0]                head_subspace;
   logic [CW-1:0]                head_centroid;
   logic [KW-1:0]                head_component;
   logic signed [VALUE_BITS-1:0] head_value;
   logic                         head_valid, head_pop;
   front_status_type             front_st;
   back_status_type              back_st;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_subspaces <= 4'd8;
         cfg_ff.centroid_bits <= 4'd8;
         cfg_ff.sub_dim       <= 5'd4;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_NUM_SUBSPACES: cfg_ff.num_subspaces <= csr_if.data[3:0];
            CSR_CENTROID_BITS: cfg_ff.centroid_bits <= csr_if.data[3:0];
            CSR_SUB_DIM:       cfg_ff.sub_dim       <= csr_if.data;
            default: ;
         endcase
      end
   end

   pqe_front #(
      .MAX_SUBSPACES(MAX_SUBSPACES), .MAX_CENTROIDS(MAX_CENTROIDS),
      .MAX_SUB_DIM(MAX_SUB_DIM), .VALUE_BITS(VALUE_BITS)
   ) u_front (
      .clock, .reset, .req_if,
      .head_ctl, .head_subspace, .head_centroid, .head_component, .head_value,
      .head_valid, .head_pop, .status(front_st)
   );

   pqe_back #(
      .MAX_SUBSPACES(MAX_SUBSPACES), .MAX_CENTROIDS(MAX_CENTROIDS),
      .MAX_SUB_DIM(MAX_SUB_DIM), .VALUE_BITS(VALUE_BITS)
   ) u_back (
      .clock, .reset, .cfg(cfg_ff),
      .head_ctl, .head_subspace, .head_centroid, .head_component, .head_value,
      .head_valid, .head_pop, .rsp_if, .status(back_st)
   );

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      front_st.count <= 2'd2) else $error("queue count exceeds its depth");
   a_result_from_pass: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(back_st.finishing))
      else $error("result appeared without a finished search");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid) else $error("pop from an empty queue");
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      back_st.finishing |-> back_st.busy) else $error("finish outside a pass");
`endif

endmodule
`default_nettype wire

>>> bench/tb_product_quantizer_encode_unit.sv
// Self-checking bench of product_quantizer_encode_unit: fills the part of the
// codebook that the stimulus reads, runs a directed table, then random phases.
// Depends on pqe_pkg, pqe_req_if, pqe_rsp_if, pqe_csr_if and the unit itself.
`timescale 1ns / 1ps
module tb_product_quantizer_encode_unit;
   import pqe_pkg::*;

   localparam int CycleLimit  = 4000000;
   localparam int DrainCycles = 1000;
   localparam int NumPhases   = 10;

   typedef struct {
      logic        func;
      logic [2:0]  book_subspace;
      logic [7:0]  book_centroid;
      logic [3:0]  book_component;
      logic signed [15:0] value;
   } req_item_type;

   typedef struct {
      logic [7:0] code;
      logic [2:0] subspace;
      logic       vector_done;
   } code_item_type;

   typedef struct {
      req_item_type item;
      bit           typed;
      logic [7:0]   code;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pqe_req_if #(.VALUE_BITS(16)) req();
   pqe_rsp_if rsp();
   pqe_csr_if csr();

   product_quantizer_encode_unit dut (
      .clock (clock),
      .reset (reset),
      .req_if(req),
      .rsp_if(rsp),
      .csr_if(csr)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the block state used to predict the codes.
   logic signed [15:0] book_mirror [8][256][16];
   longint unsigned    dist_sum [256];
   int unsigned        elem_pos, sub_pos;
   logic [3:0]         reg_subspaces, reg_cbits;
   logic [4:0]         reg_sub_dim;

   code_item_type expected_codes[$];
   int         fails = 0;
   int         cycles = 0;
   int         elems_taken = 0;
   bit         calm = 0;
   bit         send_bursts = 1;

   function automatic int unsigned eff_centroids(logic [3:0] cb);
      int unsigned b;
      b = cb;
      if (b < 4) b = 4;
      if (b > 8) b = 8;
      return 1 << b;
   endfunction

   task automatic encode_step(input req_item_type it, output bit has, output code_item_type r);
      int unsigned     ncent, sd, ns, best, s, k;
      longint          d;
      longint unsigned sq, t, bestd;
      has = 0;
      r = '{default: '0};
      if (it.func == FUNC_BOOK_WRITE) begin
         book_mirror[it.book_subspace][it.book_centroid][it.book_component] = it.value;
         return;
      end
      ncent = eff_centroids(reg_cbits);
      sd = reg_sub_dim < 1 ? 1 : (reg_sub_dim > 16 ? 16 : reg_sub_dim);
      ns = reg_subspaces < 1 ? 1 : (reg_subspaces > 8 ? 8 : reg_subspaces);
      k = elem_pos % 16;
      s = sub_pos % 8;
      for (int c = 0; c < ncent; c++) begin
         d = longint'(it.value) - longint'(book_mirror[s][c][k]);
         sq = longint'(d * d);
         if (elem_pos == 0) begin
            dist_sum[c] = sq;
         end else begin
            t = dist_sum[c] + sq;
            dist_sum[c] = (t < sq) ? '1 : t;
         end
      end
      elem_pos++;
      if (elem_pos < sd) return;
      best = 0;
      bestd = dist_sum[0];
      for (int c = 1; c < ncent; c++) begin
         if (dist_sum[c] < bestd) begin
            bestd = dist_sum[c];
            best = c;
         end
      end
      has = 1;
      r.code = best[7:0];
      r.subspace = s[2:0];
      r.vector_done = (sub_pos + 1 >= ns);
      elem_pos = 0;
      sub_pos = r.vector_done ? 0 : sub_pos + 1;
   endtask

   // Offers one item from the falling edge and returns after it is accepted.
   task automatic send_item(input req_item_type it, input bit typed, input logic [7:0] tcode);
      bit            has;
      code_item_type r;
      if (!calm && send_bursts && $urandom_range(0, 3) == 0) begin
         req.valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req.valid          = 1'b1;
      req.func           = it.func;
      req.book_subspace  = it.book_subspace;
      req.book_centroid  = it.book_centroid;
      req.book_component = it.book_component;
      req.value          = it.value;
      do @(posedge clock); while (!req.ready);
      encode_step(it, has, r);
      if (it.func == FUNC_ELEMENT) elems_taken++;
      if (has) begin
         if (typed) r.code = tcode;
         expected_codes.push_back(r);
      end
      @(negedge clock);
   endtask

   task automatic fill_word(input int s, input int c, input int k);
      req_item_type it;
      it.func           = FUNC_BOOK_WRITE;
      it.book_subspace  = 3'(s);
      it.book_centroid  = 8'(c);
      it.book_component = 4'(k);
      it.value          = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                        : 16'($signed($urandom_range(0, 6)) - 3);
      send_item(it, 1'b0, 8'd0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [4:0] data);
      csr.valid = 1'b1;
      csr.index = idx;
      csr.data  = data;
      do @(posedge clock); while (!csr.ready);
      case (idx)
         CSR_NUM_SUBSPACES: reg_subspaces = data[3:0];
         CSR_CENTROID_BITS: reg_cbits = data[3:0];
         default:           reg_sub_dim = data;
      endcase
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   // Waits until every code has come back and the back engine has settled.
   task automatic wait_idle();
      req.valid = 1'b0;
      while (expected_codes.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic set_regs(input logic [4:0] ns, input logic [4:0] cb, input logic [4:0] sd);
      wait_idle();
      write_reg(CSR_NUM_SUBSPACES, ns);
      // Centroids added in the middle of a subvector would read sums never written.
      if (elem_pos == 0 || eff_centroids(cb[3:0]) <= eff_centroids(reg_cbits))
         write_reg(CSR_CENTROID_BITS, cb);
      write_reg(CSR_SUB_DIM, sd);
   endtask

   function automatic req_item_type random_item();
      req_item_type it;
      int           pick;
      it.func           = ($urandom_range(0, 4) != 0) ? FUNC_ELEMENT : FUNC_BOOK_WRITE;
      it.book_subspace  = 3'($urandom_range(0, 7));
      it.book_centroid  = 8'($urandom_range(0, 255));
      it.book_component = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 7);
      if (pick == 0) it.value = 16'($urandom);
      else if (pick == 1) it.value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      else it.value = 16'($signed($urandom_range(0, 8)) - 4);
      return it;
   endfunction

   // Result side: random short stalls, one long hold-off once 200 elements are taken.
   initial begin
      int  hold;
      bit  held;
      hold = 0;
      held = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && elems_taken >= 200) begin
            held = 1;
            hold = 400;
         end
         if (hold > 0) begin
            rsp.ready = 1'b0;
            hold--;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp.ready = 1'b0;
            hold = $urandom_range(0, 2);
         end else begin
            rsp.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      code_item_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_codes.size() == 0) begin
            $error("code item with none expected: code %0d subspace %0d", rsp.code,
                   rsp.subspace);
            fails++;
         end else begin
            e = expected_codes.pop_front();
            if (rsp.code !== e.code) begin
               $error("code: expected %0d, actual %0d", e.code, rsp.code);
               fails++;
            end
            if (rsp.subspace !== e.subspace) begin
               $error("subspace: expected %0d, actual %0d", e.subspace, rsp.subspace);
               fails++;
            end
            if (rsp.vector_done !== e.vector_done) begin
               $error("vector_done: expected %0d, actual %0d", e.vector_done,
                      rsp.vector_done);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("product_quantizer_encode_unit verification failed");
         $finish;
      end
   end

   initial begin
      dir_row_type dir_rows[$];
      dir_row_type row;
      int          cfg_sets[4][3];
      cfg_sets = '{'{0, 15, 0}, '{1, 0, 31}, '{15, 4, 2}, '{3, 3, 0}};
      req.valid = 1'b0;
      req.func = FUNC_BOOK_WRITE;
      req.book_subspace = '0;
      req.book_centroid = '0;
      req.book_component = '0;
      req.value = '0;
      csr.valid = 1'b0;
      csr.index = CSR_NUM_SUBSPACES;
      csr.data = '0;
      elem_pos = 0;
      sub_pos = 0;
      reg_subspaces = 4'd8;
      reg_cbits = 4'd8;
      reg_sub_dim = 5'd4;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Every codebook word that an element can read is written first: the
      // first 16 centroids of all subspaces for two components, all components
      // of those centroids in subspace 0, and all centroids of subspace 0 for
      // component 0.
      send_bursts = 0;
      for (int s = 0; s < 8; s++)
         for (int c = 0; c < 16; c++)
            for (int k = 0; k < 2; k++) fill_word(s, c, k);
      for (int c = 0; c < 16; c++)
         for (int k = 2; k < 16; k++) fill_word(0, c, k);
      for (int c = 16; c < 256; c++) fill_word(0, c, 0);
      send_bursts = 1;

      // Directed part: one element per vector, 16 centroids spaced by 100.
      for (int c = 0; c < 16; c++) begin
         row = '{'{FUNC_BOOK_WRITE, 3'd0, 8'(c), 4'd0, 16'(c * 100)}, 1'b0, 8'd0};
         dir_rows.push_back(row);
      end
      dir_rows.push_back('{'{FUNC_BOOK_WRITE, 3'd7, 8'd255, 4'd15, 16'sh8000}, 1'b0, 8'd0});
      dir_rows.push_back('{'{FUNC_BOOK_WRITE, 3'd7, 8'd255, 4'd15, 16'sh7fff}, 1'b0, 8'd0});
      dir_rows.push_back('{'{FUNC_ELEMENT, 3'd7, 8'd255, 4'd15, 16'sd700}, 1'b1, 8'd7});
      dir_rows.push_back('{'{FUNC_ELEMENT, 3'd0, 8'd0, 4'd0, 16'sh8000}, 1'b1, 8'd0});
      dir_rows.push_back('{'{FUNC_ELEMENT, 3'd0, 8'd0, 4'd0, 16'sh7fff}, 1'b1, 8'd15});
      // Equal distance to centroids 7 and 8: the lower index wins.
      dir_rows.push_back('{'{FUNC_ELEMENT, 3'd0, 8'd0, 4'd0, 16'sd750}, 1'b1, 8'd7});
      dir_rows.push_back('{'{FUNC_ELEMENT, 3'd0, 8'd0, 4'd0, 16'sd0}, 1'b1, 8'd0});
      set_regs(5'd1, 5'd4, 5'd1);
      foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].code);

      // Random phases. The first two reach 256 centroids and 16 elements per
      // subvector while staying in subspace 0; later ones keep 16 centroids
      // and at most two elements, inside the written part of the codebook.
      for (int p = 0; p < NumPhases; p++) begin
         if (p < 4)
            set_regs(5'(cfg_sets[p][0]), 5'(cfg_sets[p][1]), 5'(cfg_sets[p][2]));
         else
            set_regs(5'($urandom_range(0, 15)), 5'($urandom_range(0, 4)),
                     5'($urandom_range(0, 2)));
         calm = (p == NumPhases - 1);
         for (int n = 0; n < ((p == 0) ? 30 : ((p == 1) ? 50 : 40)); n++)
            send_item(random_item(), 1'b0, 8'd0);
      end

      wait_idle();
      if (fails == 0 && expected_codes.size() == 0) begin
         $display("product_quantizer_encode_unit verification clean");
      end else begin
         $display("product_quantizer_encode_unit verification failed");
      end
      $finish;
   end
endmodule

>>> filelist.f
hdl/pqe_pkg.sv
hdl/pqe_req_if.sv
hdl/pqe_rsp_if.sv
hdl/pqe_csr_if.sv
hdl/pqe_front.sv
hdl/pqe_back.sv
hdl/product_quantizer_encode_unit.sv
bench/tb_product_quantizer_encode_unit.sv
